/* rtl/ssgd_pkg.sv */
// package for the slider scroll gesture detector
// types, register indexes, reset values and gesture codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ssgd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int THR_W      = 9;
  localparam int LIMIT_W    = 10;
  localparam int TILT_W     = 10;
  localparam int GEST_W     = 3;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [GEST_W-1:0]     gesture_t;

  // register indexes
  localparam cfg_idx_t CFG_SLIDE_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_MODE_THRESHOLD  = 2'd1;
  localparam cfg_idx_t CFG_SHAKE_LIMIT     = 2'd2;
  localparam cfg_idx_t CFG_SELECT_LIMIT    = 2'd3;

  // register reset values
  localparam logic [THR_W-1:0]          SLIDE_THRESHOLD_RST = 9'd7;
  localparam logic [THR_W-1:0]          MODE_THRESHOLD_RST  = 9'd5;
  localparam logic signed [LIMIT_W-1:0] SHAKE_LIMIT_RST     = 10'sd150;
  localparam logic [LIMIT_W-1:0]        SELECT_LIMIT_RST    = 10'd550;

  // non-negative slopes at or below this never open the gate while moving down
  localparam int NOISE_FLOOR = 4;

  // gesture codes
  localparam gesture_t GEST_NONE   = 3'd0;
  localparam gesture_t GEST_UP     = 3'd1;
  localparam gesture_t GEST_DOWN   = 3'd2;
  localparam gesture_t GEST_SHAKE  = 3'd3;
  localparam gesture_t GEST_SELECT = 3'd4;

endpackage
`default_nettype wire

/* rtl/ssgd_if.sv */
// valid/ready channel interfaces for the slider scroll gesture detector
// depends on ssgd_pkg
`timescale 1ns / 1ps
`default_nettype none
interface ssgd_in_if #(
  parameter int LEVEL_BITS = 10
);
  import ssgd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [LEVEL_BITS-1:0]      up_level;
  logic [LEVEL_BITS-1:0]      down_level;
  logic signed [TILT_W-1:0]   tilt_y;
  logic [LEVEL_BITS-1:0]      select_level;

  modport source (output valid, up_level, down_level, tilt_y, select_level, input ready);
  modport sink   (input valid, up_level, down_level, tilt_y, select_level, output ready);
endinterface

interface ssgd_out_if;
  import ssgd_pkg::*;
  logic     valid;
  logic     ready;
  gesture_t gesture;

  modport source (output valid, gesture, input ready);
  modport sink   (input valid, gesture, output ready);
endinterface
`default_nettype wire

/* rtl/slider_scroll_gesture_detector.sv */
// slider scroll gesture detector top level
// depends on ssgd_pkg and the channel interfaces in ssgd_if.sv
// the single output register holds an accepted transaction's result from the next cycle
// throughput: one transaction per cycle when drained; the register frees in the cycle it is taken
// the slope divider, gate, history compares and priority pick all sit in one combinational pass
// reset (rst_n low, synchronous): thresholds and limits to their defaults, difference taps and
// slope history to zero, direction flags to moving down, output register empty
`timescale 1ns / 1ps
`default_nettype none
module slider_scroll_gesture_detector #(
  parameter int HISTORY_DEPTH = 8,
  parameter int SLOPE_SPAN    = 4,
  parameter int LEVEL_BITS    = 10
) (
  input  wire                  clk,
  input  wire                  rst_n,
  ssgd_in_if.sink              in_ch,
  ssgd_out_if.source           out_ch,
  input  wire                  cfg_we,
  input  wire ssgd_pkg::cfg_idx_t  cfg_index,
  input  wire ssgd_pkg::cfg_data_t cfg_data
);
  import ssgd_pkg::*;

  // difference up - down and its magnitude after subtracting an older one
  localparam int DIFF_W  = LEVEL_BITS + 1;
  localparam int RAW_W   = DIFF_W + 1;
  localparam int MAG_W   = DIFF_W;
  // largest slope magnitude and the signed width that holds it
  localparam int QMAX    = (2 * ((1 << LEVEL_BITS) - 1)) / SLOPE_SPAN;
  localparam int SLOPE_W = $clog2(QMAX + 1) + 1;
  // reciprocal for truncating division of the magnitude by the span
  localparam int RSH     = MAG_W + 2;
  localparam int PROD_W  = MAG_W + RSH + 1;
  localparam logic [RSH:0] RECIP = (RSH+1)'(((1 << RSH) + SLOPE_SPAN - 1) / SLOPE_SPAN);
  // common signed compare width for slopes against thresholds
  localparam int CMP_W   = ((SLOPE_W > THR_W) ? SLOPE_W : THR_W) + 2;
  localparam int SEL_W   = ((LEVEL_BITS > LIMIT_W) ? LEVEL_BITS : LIMIT_W);

  // configuration registers
  logic [THR_W-1:0]          slide_thr_r;
  logic [THR_W-1:0]          mode_thr_r;
  logic signed [LIMIT_W-1:0] shake_lim_r;
  logic [LIMIT_W-1:0]        select_lim_r;

  // the ring only ever supplies the difference SLOPE_SPAN back, and its depth
  // exceeds the span, so it is kept as a tap line of the last SLOPE_SPAN entries
  logic signed [DIFF_W-1:0]  tap_r   [SLOPE_SPAN];
  logic signed [DIFF_W-1:0]  tap_nxt [SLOPE_SPAN];

  // the scroll check looks at every entry alike, so history order is free:
  // a shift line where the newest slope enters at entry zero
  logic signed [SLOPE_W-1:0] hist_r   [HISTORY_DEPTH];
  logic signed [SLOPE_W-1:0] hist_nxt [HISTORY_DEPTH];

  logic moving_up_r,   moving_up_nxt;
  logic moving_down_r, moving_down_nxt;

  // output register
  logic     out_valid_r;
  gesture_t gesture_r, gesture_nxt;

  logic in_acc;
  logic out_acc;

  logic signed [DIFF_W-1:0]  diff_new;
  logic signed [RAW_W-1:0]   slope_raw;
  logic                      slope_neg;
  logic [MAG_W-1:0]          slope_mag;
  logic [PROD_W-1:0]         slope_prod;
  logic [SLOPE_W-1:0]        quot;
  logic signed [SLOPE_W-1:0] slope;

  logic signed [CMP_W-1:0]   slope_c;
  logic signed [CMP_W-1:0]   slide_c;
  logic signed [CMP_W-1:0]   mode_c;
  logic                      gate;
  logic                      all_up;
  logic                      all_dn;

  // a new transaction enters whenever the output register is empty or being drained
  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_acc       = out_valid_r && out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.gesture = gesture_r;

  // slope: (newest difference - difference SLOPE_SPAN back) / SLOPE_SPAN, toward zero
  always_comb begin
    diff_new   = $signed({1'b0, in_ch.up_level}) - $signed({1'b0, in_ch.down_level});
    slope_raw  = RAW_W'(diff_new) - RAW_W'(tap_r[SLOPE_SPAN-1]);
    slope_neg  = slope_raw[RAW_W-1];
    slope_mag  = slope_neg ? MAG_W'(-slope_raw) : MAG_W'(slope_raw);
    slope_prod = PROD_W'(slope_mag) * PROD_W'(RECIP);
    quot       = SLOPE_W'(slope_prod >> RSH);
    slope      = slope_neg ? $signed(-quot) : $signed(quot);
  end

  // direction-dependent hysteresis gate
  always_comb begin
    slope_c = CMP_W'(slope);
    slide_c = CMP_W'($signed({1'b0, slide_thr_r}));
    mode_c  = CMP_W'($signed({1'b0, mode_thr_r}));
    gate = (moving_down_r && (slope_c > CMP_W'(NOISE_FLOOR)) && (slope_c > slide_c)) ||
           (moving_down_r && (slope_c < 0)) ||
           (moving_up_r && (slope_c < -slide_c)) ||
           (moving_up_r && (slope_c > 0));
  end

  // shift lines and the all-entries scroll check on the updated history
  always_comb begin
    tap_nxt[0] = diff_new;
    for (int i = 1; i < SLOPE_SPAN; i++) begin
      tap_nxt[i] = tap_r[i-1];
    end
    hist_nxt[0] = slope;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i-1];
    end
    all_up = 1'b1;
    all_dn = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (!(CMP_W'(hist_nxt[i]) > mode_c)) all_up = 1'b0;
      if (!(CMP_W'(hist_nxt[i]) < -mode_c)) all_dn = 1'b0;
    end
  end

  // gesture priority: scroll down, scroll up, shake, select
  always_comb begin
    gesture_nxt     = GEST_NONE;
    moving_up_nxt   = moving_up_r;
    moving_down_nxt = moving_down_r;
    if (gate) begin
      if (all_dn) begin
        gesture_nxt     = GEST_DOWN;
        moving_down_nxt = 1'b1;
        moving_up_nxt   = 1'b0;
      end else if (all_up) begin
        gesture_nxt     = GEST_UP;
        moving_up_nxt   = 1'b1;
        moving_down_nxt = 1'b0;
      end else if (in_ch.tilt_y > shake_lim_r) begin
        gesture_nxt = GEST_SHAKE;
      end else if (SEL_W'(in_ch.select_level) <= SEL_W'(select_lim_r)) begin
        gesture_nxt = GEST_SELECT;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slide_thr_r  <= SLIDE_THRESHOLD_RST;
      mode_thr_r   <= MODE_THRESHOLD_RST;
      shake_lim_r  <= SHAKE_LIMIT_RST;
      select_lim_r <= SELECT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLIDE_THRESHOLD: slide_thr_r  <= cfg_data[THR_W-1:0];
        CFG_MODE_THRESHOLD:  mode_thr_r   <= cfg_data[THR_W-1:0];
        CFG_SHAKE_LIMIT:     shake_lim_r  <= $signed(cfg_data[LIMIT_W-1:0]);
        CFG_SELECT_LIMIT:    select_lim_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // detector state; the tap line moves on every transaction, the history only on a gate pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOPE_SPAN; i++) tap_r[i] <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[i] <= '0;
      moving_up_r   <= 1'b0;
      moving_down_r <= 1'b1;
    end else if (in_acc) begin
      tap_r         <= tap_nxt;
      moving_up_r   <= moving_up_nxt;
      moving_down_r <= moving_down_nxt;
      if (gate) hist_r <= hist_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) gesture_r <= gesture_nxt;
  end

  // the direction flags always name exactly one direction
  a_dir_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({moving_up_r, moving_down_r}))
    else $error("direction flags not one-hot");

  // every accepted transaction leaves a result in the output register
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transaction left no result");

  // a scroll up report switches the direction to up
  a_up_sets_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && gesture_nxt == GEST_UP) |=> (moving_up_r && gesture_r == GEST_UP))
    else $error("scroll up did not set direction");

  // a failed gate leaves the direction untouched and reports nothing
  a_gate_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !gate) |=> ($stable({moving_up_r, moving_down_r}) && gesture_r == GEST_NONE))
    else $error("failed gate changed state or reported a gesture");

endmodule
`default_nettype wire
